/* rtl/core/isqrt_pkg.sv */
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared constant for the integer square root block.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  // width of the root field on the result channel
  localparam int unsigned ROOT_WIDTH = 16;

endpackage : isqrt_pkg

/* rtl/core/isqrt_radicand_if.sv */
// ----------------------------------------------------------------------------
// isqrt_radicand_if
// Valid/ready channel carrying one radicand word.
// ----------------------------------------------------------------------------
interface isqrt_radicand_if #(
  parameter int unsigned VALUE_WIDTH = 31
);

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);

endinterface : isqrt_radicand_if

/* rtl/core/isqrt_root_if.sv */
// ----------------------------------------------------------------------------
// isqrt_root_if
// Valid/ready channel carrying one root word.
// ----------------------------------------------------------------------------
interface isqrt_root_if;

  logic                            valid;
  logic                            ready;
  logic [isqrt_pkg::ROOT_WIDTH-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);

endinterface : isqrt_root_if

/* rtl/core/isqrt_cell.sv */
// ----------------------------------------------------------------------------
// isqrt_cell
// One step of the digit-by-digit square root: brings down the next bit pair,
// tries the trial divisor and settles one root bit.
// ----------------------------------------------------------------------------
module isqrt_cell #(
  parameter int unsigned ROOT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   up_valid,
  input  logic [ROOT_BITS+1:0]   up_rem,
  input  logic [ROOT_BITS-1:0]   up_root,
  input  logic [2*ROOT_BITS-1:0] up_val,
  output logic                   dn_valid,
  output logic [ROOT_BITS+1:0]   dn_rem,
  output logic [ROOT_BITS-1:0]   dn_root,
  output logic [2*ROOT_BITS-1:0] dn_val
);

  localparam int unsigned PairW = 2 * ROOT_BITS;
  localparam int unsigned RemW  = ROOT_BITS + 2;
  localparam int unsigned WideW = ROOT_BITS + 4;

  logic [WideW-1:0]     shifted;
  logic [WideW-1:0]     trial;
  logic [WideW-1:0]     diff;
  logic                 fits;
  logic [RemW-1:0]      rem_next;
  logic [ROOT_BITS-1:0] root_next;
  logic [PairW-1:0]     val_next;

  always_comb begin
    // remainder with the next bit pair brought down
    shifted   = {up_rem, up_val[PairW-1 -: 2]};
    trial     = WideW'({up_root, 2'b01});
    diff      = shifted - trial;
    fits      = (shifted >= trial);
    rem_next  = fits ? diff[RemW-1:0] : shifted[RemW-1:0];
    root_next = ROOT_BITS'({up_root, fits});
    val_next  = up_val << 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (advance) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dn_rem  <= rem_next;
      dn_root <= root_next;
      dn_val  <= val_next;
    end
  end

endmodule : isqrt_cell

/* rtl/core/integer_square_root_newton_top.sv */
// ----------------------------------------------------------------------------
// integer_square_root_newton_top
// Floor square root of an unsigned radicand, one root word per radicand word.
// ----------------------------------------------------------------------------
// Usage:
//   operand : sink of radicand words (valid/ready, word taken when both high)
//   result  : source of root words, root = floor(sqrt(radicand)), low 16 bits
//   The radicand runs down a row of (VALUE_WIDTH+1)/2 cells, one root bit per
//   cell and per cycle while the row is not stalled, then lands in an output
//   register. One word is worked on at a time: a new radicand is taken only
//   once the last root has been handed to the output register.
//   The next radicand is taken while a finished root still waits in the
//   output register. If the receiver stalls with the output register full,
//   the word in the last cell holds until the register drains.
//   Reset (rst, synchronous) empties the cell row and the output register;
//   nothing is kept between words.
// ----------------------------------------------------------------------------
module integer_square_root_newton_top #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic         clk,
  input  logic         rst,
  isqrt_radicand_if.sink operand,
  isqrt_root_if.source   result
);

  localparam int unsigned RootBits = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned PairW    = 2 * RootBits;
  localparam int unsigned RemW     = RootBits + 2;

  logic                busy;
  logic                advance;
  logic                accept;
  logic                out_load;
  logic                out_valid;
  logic [isqrt_pkg::ROOT_WIDTH-1:0] out_root;

  logic [RootBits:0]   stage_valid;
  logic [RemW-1:0]     stage_rem  [RootBits+1];
  logic [RootBits-1:0] stage_root [RootBits+1];
  logic [PairW-1:0]    stage_val  [RootBits+1];

  assign accept   = operand.valid && operand.ready;
  assign out_load = stage_valid[RootBits] && (!out_valid || result.ready);
  // the row only stalls when the last cell cannot hand its word on
  assign advance  = !(stage_valid[RootBits] && !out_load);

  assign operand.ready = !busy;

  assign stage_valid[0] = accept;
  assign stage_rem[0]   = '0;
  assign stage_root[0]  = '0;
  assign stage_val[0]   = PairW'(operand.radicand);

  for (genvar i = 0; i < RootBits; i++) begin : g_cell
    isqrt_cell #(
      .ROOT_BITS (RootBits)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .up_valid (stage_valid[i]),
      .up_rem   (stage_rem[i]),
      .up_root  (stage_root[i]),
      .up_val   (stage_val[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_rem   (stage_rem[i+1]),
      .dn_root  (stage_root[i+1]),
      .dn_val   (stage_val[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root <= isqrt_pkg::ROOT_WIDTH'(stage_root[RootBits]);
    end
  end

  assign result.valid = out_valid;
  assign result.root  = out_root;

`ifndef ASSERT_OFF
  // only one word is ever in the cell row
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stage_valid[RootBits:1]))
    else $error("more than one word in the cell row");

  // an idle block has an empty cell row
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (stage_valid[RootBits:1] == '0))
    else $error("cell row holds a word while idle");

  // a blocked last cell keeps its word
  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[RootBits] && !out_load) |=> stage_valid[RootBits])
    else $error("stalled word dropped from last cell");

  // handing the word to the output register frees the block
  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (!busy && out_valid))
    else $error("block still busy after result load");
`endif

endmodule : integer_square_root_newton_top
